// File: rtl/vgrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrc_pkg
// Shared types, codes and widths of the voxel grid store with ray caster.
// ----------------------------------------------------------------------------
package vgrc_pkg;

    // default geometry
    localparam int DEF_CHUNK_WIDTH         = 16;
    localparam int DEF_CHUNK_HEIGHT        = 16;
    localparam int DEF_CHUNK_LENGTH        = 16;
    localparam int DEF_MAX_CHUNKS_PER_AXIS = 4;
    localparam int DEF_VOXEL_ID_BITS       = 8;

    localparam int RAY_MAX_STEPS = 256;
    localparam int STEP_W        = $clog2(RAY_MAX_STEPS + 1);

    localparam int FIX_W     = 32;
    localparam int COORD_W   = 16;
    localparam int CELL_W    = 18;
    localparam int DELTA_W   = 33;
    localparam int DIST_W    = 17;
    localparam int T_W       = 42;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = 59;
    localparam int SUM_W     = PROD_W + 2;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int VALUE_W   = 8;
    localparam int MASK_W    = 7;
    localparam int NORMAL_W  = 3;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CAST  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_Z = 2'd2;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [NORMAL_W-1:0] NORMAL_NONE = 3'd0;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [15:0]       voxel_x;
        logic signed [15:0]       voxel_y;
        logic signed [15:0]       voxel_z;
        logic [7:0]               voxel_value;
        logic signed [31:0]       origin_x;
        logic signed [31:0]       origin_y;
        logic signed [31:0]       origin_z;
        logic signed [31:0]       direction_x;
        logic signed [31:0]       direction_y;
        logic signed [31:0]       direction_z;
        logic signed [31:0]       max_distance;
    } vgrc_in_t;

    typedef struct packed {
        logic                     found;
        logic [7:0]               value_out;
        logic signed [15:0]       cell_x;
        logic signed [15:0]       cell_y;
        logic signed [15:0]       cell_z;
        logic signed [31:0]       end_x;
        logic signed [31:0]       end_y;
        logic signed [31:0]       end_z;
        logic [2:0]               normal_code;
        logic [6:0]               marked_mask;
    } vgrc_out_t;

    typedef struct packed {
        logic       capture;
        logic       clr_we;
        logic       mem_done;
        logic       div_start;
        logic       div_store;
        logic       tm_mul;
        logic       tm_store;
        logic       loop_step;
        logic       hit_store;
        logic       e_lo;
        logic       e_hi;
        logic       e_sum;
        logic       e_store;
        logic       load_out;
        logic [1:0] axis;
    } vgrc_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] action;
        logic       d_zero;
        logic       div_done;
        logic       loop_go;
        logic       hit;
        logic       steps_max;
    } vgrc_stat_t;

endpackage

// File: rtl/vgrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vgrc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/vgrc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vgrc_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             take;

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign take    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            quot_reg <= {quot_reg[NUM_W-2:0], take};
            rem_reg  <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

// File: rtl/vgrc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrc_datapath
// Voxel store, coordinate split, traversal registers and end point math.
// ----------------------------------------------------------------------------
module vgrc_datapath #(
    parameter int CHUNK_WIDTH         = vgrc_pkg::DEF_CHUNK_WIDTH,
    parameter int CHUNK_HEIGHT        = vgrc_pkg::DEF_CHUNK_HEIGHT,
    parameter int CHUNK_LENGTH        = vgrc_pkg::DEF_CHUNK_LENGTH,
    parameter int MAX_CHUNKS_PER_AXIS = vgrc_pkg::DEF_MAX_CHUNKS_PER_AXIS,
    parameter int VOXEL_ID_BITS       = vgrc_pkg::DEF_VOXEL_ID_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vgrc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vgrc_pkg::CFG_W-1:0]           cfg_data,
    input  vgrc_pkg::vgrc_in_t                   in_data,
    output vgrc_pkg::vgrc_out_t                  out_data,
    input  vgrc_pkg::vgrc_cmd_t                  cmd,
    output vgrc_pkg::vgrc_stat_t                 stat
);

    import vgrc_pkg::*;

    localparam int VOL     = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_LENGTH;
    localparam int DEPTH   = MAX_CHUNKS_PER_AXIS * MAX_CHUNKS_PER_AXIS
                             * MAX_CHUNKS_PER_AXIS * VOL;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W    = (MAX_CHUNKS_PER_AXIS > 1) ? $clog2(MAX_CHUNKS_PER_AXIS) : 1;
    localparam int DIM_XZ  = (CHUNK_WIDTH > CHUNK_LENGTH) ? CHUNK_WIDTH : CHUNK_LENGTH;
    localparam int DIM_MAX = (DIM_XZ > CHUNK_HEIGHT) ? DIM_XZ : CHUNK_HEIGHT;
    localparam int LOC_W   = $clog2(DIM_MAX);

    typedef struct packed {
        logic            in_range;
        logic [CH_W-1:0] chunk;
        logic [LOC_W-1:0] offset;
    } split_t;

    function automatic split_t split_axis(input logic signed [CELL_W-1:0] v,
                                          input int dim, input int ext);
        split_t r;
        int     vi;
        int     base;
        vi       = int'(v);
        base     = 0;
        r.chunk  = '0;
        for (int j = 1; j < MAX_CHUNKS_PER_AXIS; j++)
        begin
            if (vi >= j * dim)
            begin
                r.chunk = CH_W'(j);
                base    = j * dim;
            end
        end
        r.in_range = (vi >= 0) && (vi < ext * dim);
        r.offset   = LOC_W'(vi - base);
        return r;
    endfunction

    function automatic int extent(input logic [CFG_W-1:0] r);
        return (int'(r) > MAX_CHUNKS_PER_AXIS) ? MAX_CHUNKS_PER_AXIS : int'(r);
    endfunction

    function automatic logic [COORD_W-1:0] sat16(input logic signed [CELL_W-1:0] v);
        if (v > CELL_W'(32767))
            return 16'h7fff;
        else if (v < -CELL_W'(32768))
            return 16'h8000;
        else
            return v[COORD_W-1:0];
    endfunction

    // configuration
    logic [CFG_W-1:0] cfg_x_reg, cfg_y_reg, cfg_z_reg;
    int               ext_x, ext_y, ext_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_x_reg <= CFG_W'(4);
            cfg_y_reg <= CFG_W'(4);
            cfg_z_reg <= CFG_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHUNKS_X: cfg_x_reg <= cfg_data;
                CFG_CHUNKS_Y: cfg_y_reg <= cfg_data;
                CFG_CHUNKS_Z: cfg_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign ext_x = extent(cfg_x_reg);
    assign ext_y = extent(cfg_y_reg);
    assign ext_z = extent(cfg_z_reg);

    // item registers
    vgrc_in_t                   in_reg;
    logic signed [CELL_W-1:0]   cell_reg  [3];
    logic [DELTA_W-1:0]         delta_reg [3];
    logic [T_W-1:0]             tm_reg    [3];
    logic signed [FIX_W-1:0]    end_reg   [3];
    logic [T_W-1:0]             t_reg;
    logic                       t_inf_reg;
    logic [STEP_W-1:0]          steps_reg;
    logic [1:0]                 axis_last_reg;
    logic                       found_reg;
    logic [VALUE_W-1:0]         value_reg;
    logic [MASK_W-1:0]          mask_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [PROD_W-1:0]          acc_reg;
    vgrc_out_t                  out_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;

    logic signed [FIX_W-1:0]    o_a    [3];
    logic signed [FIX_W-1:0]    d_a    [3];
    logic [FIX_W-1:0]           dabs_a [3];
    logic                       pos_a  [3];
    logic                       act_a  [3];
    logic [DIST_W-1:0]          dist_a [3];

    assign o_a[0] = in_reg.origin_x;
    assign o_a[1] = in_reg.origin_y;
    assign o_a[2] = in_reg.origin_z;
    assign d_a[0] = in_reg.direction_x;
    assign d_a[1] = in_reg.direction_y;
    assign d_a[2] = in_reg.direction_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pos_a[k]  = d_a[k] > 0;
            act_a[k]  = d_a[k] != 0;
            dabs_a[k] = d_a[k][FIX_W-1] ? -d_a[k] : d_a[k];
            dist_a[k] = pos_a[k] ? (DIST_W'(65536) - DIST_W'(o_a[k][15:0]))
                                 : DIST_W'(o_a[k][15:0]);
        end
    end

    logic [1:0]              ax;
    logic signed [FIX_W-1:0] o_sel;
    logic signed [FIX_W-1:0] d_sel;
    logic [FIX_W-1:0]        dabs_sel;

    assign ax       = cmd.axis;
    assign o_sel    = o_a[ax];
    assign d_sel    = d_a[ax];
    assign dabs_sel = dabs_a[ax];

    // locate current cell
    split_t            sx, sy, sz;
    logic              in_world;
    logic [ADDR_W-1:0] cell_addr;

    assign sx = split_axis(cell_reg[0], CHUNK_WIDTH, ext_x);
    assign sy = split_axis(cell_reg[1], CHUNK_HEIGHT, ext_y);
    assign sz = split_axis(cell_reg[2], CHUNK_LENGTH, ext_z);
    assign in_world = sx.in_range && sy.in_range && sz.in_range;
    assign cell_addr = ADDR_W'(((int'(sy.chunk) * MAX_CHUNKS_PER_AXIS + int'(sz.chunk))
                                * MAX_CHUNKS_PER_AXIS + int'(sx.chunk)) * VOL
                               + (int'(sy.offset) * CHUNK_LENGTH + int'(sz.offset))
                                 * CHUNK_WIDTH + int'(sx.offset));

    logic [MASK_W-1:0] mask_calc;

    always_comb
    begin
        mask_calc    = '0;
        mask_calc[0] = 1'b1;
        mask_calc[1] = (sx.offset == '0) && (sx.chunk != '0);
        mask_calc[2] = (int'(sx.offset) == CHUNK_WIDTH - 1) && (int'(sx.chunk) + 1 < ext_x);
        mask_calc[3] = (sy.offset == '0) && (sy.chunk != '0);
        mask_calc[4] = (int'(sy.offset) == CHUNK_HEIGHT - 1) && (int'(sy.chunk) + 1 < ext_y);
        mask_calc[5] = (sz.offset == '0) && (sz.chunk != '0);
        mask_calc[6] = (int'(sz.offset) == CHUNK_LENGTH - 1) && (int'(sz.chunk) + 1 < ext_z);
    end

    // store
    logic [VOXEL_ID_BITS-1:0] rd_data;
    logic [VOXEL_ID_BITS-1:0] new_id;
    logic                     wr_commit;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [VOXEL_ID_BITS-1:0] ram_wdata;

    assign new_id    = VOXEL_ID_BITS'(in_reg.voxel_value);
    assign wr_commit = cmd.mem_done && (in_reg.action == ACT_WRITE) && in_world
                       && (rd_data != new_id);
    assign ram_we    = cmd.clr_we || wr_commit;
    assign ram_waddr = cmd.clr_we ? clr_addr_reg : cell_addr;
    assign ram_wdata = cmd.clr_we ? '0 : new_id;

    vgrc_ram #(
        .WIDTH (VOXEL_ID_BITS),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(cell_addr),
        .rdata(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_we)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // reciprocal of the direction magnitude
    logic [DELTA_W-1:0] div_quot;
    logic               div_done;

    vgrc_div #(
        .NUM_W(DELTA_W),
        .DEN_W(FIX_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .num  (DELTA_W'(1) << FIX_W),
        .den  (dabs_sel),
        .quot (div_quot),
        .done (div_done)
    );

    // shared multiplier
    logic [T_W-1:0]     mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_next;

    always_comb
    begin
        if (cmd.tm_mul)
        begin
            mul_a = T_W'(delta_reg[ax]);
            mul_b = dist_a[ax];
        end
        else if (cmd.e_hi)
        begin
            mul_a = t_reg;
            mul_b = MUL_B_W'(dabs_sel[31:16]);
        end
        else
        begin
            mul_a = t_reg;
            mul_b = MUL_B_W'(dabs_sel[15:0]);
        end
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // next axis to step, ties to the later axis
    logic       lxy, lxz, lyz;
    logic [1:0] ks;

    assign lxy = act_a[0] && (!act_a[1] || tm_reg[0] < tm_reg[1]);
    assign lxz = act_a[0] && (!act_a[2] || tm_reg[0] < tm_reg[2]);
    assign lyz = act_a[1] && (!act_a[2] || tm_reg[1] < tm_reg[2]);
    assign ks  = lxy ? (lxz ? 2'd0 : 2'd2) : (lyz ? 2'd1 : 2'd2);

    // end point sum with saturation
    logic signed [SUM_W-1:0] q_ext;
    logic signed [SUM_W-1:0] sum;
    logic signed [FIX_W-1:0] sum_sat;

    always_comb
    begin
        q_ext = $signed({2'b00, acc_reg});
        sum   = SUM_W'(o_sel) + (d_sel[FIX_W-1] ? -q_ext : q_ext);
        if (!sum[SUM_W-1] && (sum[SUM_W-2:FIX_W-1] != '0))
            sum_sat = 32'sh7fffffff;
        else if (sum[SUM_W-1] && (sum[SUM_W-2:FIX_W-1] != '1))
            sum_sat = 32'sh80000000;
        else
            sum_sat = sum[FIX_W-1:0];
    end

    logic [NORMAL_W-1:0] normal;
    logic                is_cast;

    assign is_cast = in_reg.action == ACT_CAST;

    always_comb
    begin
        normal = NORMAL_NONE;
        if (is_cast && found_reg && (axis_last_reg != AXIS_NONE))
            normal = {axis_last_reg, 1'b0} + (pos_a[axis_last_reg] ? 3'd1 : 3'd2);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg        <= in_data;
            found_reg     <= 1'b0;
            value_reg     <= '0;
            mask_reg      <= '0;
            t_reg         <= '0;
            t_inf_reg     <= 1'b0;
            steps_reg     <= '0;
            axis_last_reg <= AXIS_NONE;
            for (int k = 0; k < 3; k++)
                end_reg[k] <= '0;
            if (in_data.action == ACT_CAST)
            begin
                cell_reg[0] <= CELL_W'(in_data.origin_x >>> 16);
                cell_reg[1] <= CELL_W'(in_data.origin_y >>> 16);
                cell_reg[2] <= CELL_W'(in_data.origin_z >>> 16);
            end
            else
            begin
                cell_reg[0] <= CELL_W'(in_data.voxel_x);
                cell_reg[1] <= CELL_W'(in_data.voxel_y);
                cell_reg[2] <= CELL_W'(in_data.voxel_z);
            end
        end

        if (cmd.mem_done)
        begin
            found_reg <= in_world;
            if (in_reg.action == ACT_READ)
                value_reg <= in_world ? VALUE_W'(rd_data) : '0;
            if (wr_commit)
                mask_reg <= mask_calc;
        end

        if (cmd.hit_store)
        begin
            found_reg <= 1'b1;
            value_reg <= VALUE_W'(rd_data);
        end

        for (int k = 0; k < 3; k++)
        begin
            if (cmd.div_store && (ax == 2'(k)))
                delta_reg[k] <= act_a[k] ? div_quot : '0;
            if (cmd.tm_store && (ax == 2'(k)))
                tm_reg[k] <= T_W'(prod_reg >> 16);
            if (cmd.loop_step && (ks == 2'(k)))
            begin
                cell_reg[k] <= cell_reg[k] + (pos_a[k] ? CELL_W'(1) : -CELL_W'(1));
                if (act_a[k])
                    tm_reg[k] <= tm_reg[k] + T_W'(delta_reg[k]);
            end
            if (cmd.e_store && (ax == 2'(k)))
                end_reg[k] <= t_inf_reg ? o_a[k] : sum_sat;
        end

        if (cmd.loop_step)
        begin
            steps_reg     <= steps_reg + 1'b1;
            axis_last_reg <= ks;
            if (!act_a[ks])
                t_inf_reg <= 1'b1;
            else
                t_reg <= tm_reg[ks];
        end

        if (cmd.tm_mul || cmd.e_lo || cmd.e_hi)
            prod_reg <= prod_next;
        if (cmd.e_hi)
            acc_reg <= prod_reg >> 16;
        else if (cmd.e_sum)
            acc_reg <= acc_reg + prod_reg;

        if (cmd.load_out)
        begin
            out_reg.found       <= found_reg;
            out_reg.value_out   <= value_reg;
            out_reg.cell_x      <= is_cast ? sat16(cell_reg[0]) : '0;
            out_reg.cell_y      <= is_cast ? sat16(cell_reg[1]) : '0;
            out_reg.cell_z      <= is_cast ? sat16(cell_reg[2]) : '0;
            out_reg.end_x       <= end_reg[0];
            out_reg.end_y       <= end_reg[1];
            out_reg.end_z       <= end_reg[2];
            out_reg.normal_code <= normal;
            out_reg.marked_mask <= mask_reg;
        end
    end

    assign out_data = out_reg;

    assign stat.clr_done  = clr_addr_reg == ADDR_W'(DEPTH - 1);
    assign stat.action    = in_reg.action;
    assign stat.d_zero    = !act_a[ax];
    assign stat.div_done  = div_done;
    assign stat.loop_go   = !t_inf_reg && !in_reg.max_distance[FIX_W-1]
                            && (t_reg <= T_W'($unsigned(in_reg.max_distance)));
    assign stat.hit       = in_world && (rd_data != '0);
    assign stat.steps_max = steps_reg == STEP_W'(RAY_MAX_STEPS);

endmodule

// File: rtl/vgrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrc_ctrl
// Sequencer for store clearing, voxel access, traversal and result transfer.
// ----------------------------------------------------------------------------
module vgrc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output vgrc_pkg::vgrc_cmd_t  cmd,
    input  vgrc_pkg::vgrc_stat_t stat
);

    import vgrc_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_MEM_CHK  = 4'd3;
    localparam logic [3:0] S_DIV_GO   = 4'd4;
    localparam logic [3:0] S_DIV_WAIT = 4'd5;
    localparam logic [3:0] S_TM_MUL   = 4'd6;
    localparam logic [3:0] S_TM_ST    = 4'd7;
    localparam logic [3:0] S_LOOP_RD  = 4'd8;
    localparam logic [3:0] S_LOOP_CHK = 4'd9;
    localparam logic [3:0] S_E_LO     = 4'd10;
    localparam logic [3:0] S_E_HI     = 4'd11;
    localparam logic [3:0] S_E_SUM    = 4'd12;
    localparam logic [3:0] S_E_ST     = 4'd13;
    localparam logic [3:0] S_FINISH   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.axis   = axis_reg;
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                // store read of the addressed voxel is under way here
                unique case (stat.action)
                    ACT_CAST:
                    begin
                        axis_next  = AXIS_X;
                        state_next = S_DIV_GO;
                    end
                    ACT_NONE:  state_next = S_FINISH;
                    default:   state_next = S_MEM_CHK;
                endcase
            end
            S_MEM_CHK:
            begin
                cmd.mem_done = 1'b1;
                state_next   = S_FINISH;
            end
            S_DIV_GO:
            begin
                if (stat.d_zero)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_TM_MUL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_TM_MUL;
                end
            end
            S_TM_MUL:
            begin
                cmd.tm_mul = 1'b1;
                state_next = S_TM_ST;
            end
            S_TM_ST:
            begin
                cmd.tm_store = 1'b1;
                if (axis_reg == AXIS_Z)
                begin
                    axis_next  = AXIS_X;
                    state_next = S_LOOP_RD;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_DIV_GO;
                end
            end
            S_LOOP_RD:
            begin
                state_next = stat.loop_go ? S_LOOP_CHK : S_E_LO;
            end
            S_LOOP_CHK:
            begin
                priority if (stat.hit)
                begin
                    cmd.hit_store = 1'b1;
                    state_next    = S_E_LO;
                end
                else if (stat.steps_max)
                begin
                    state_next = S_E_LO;
                end
                else
                begin
                    cmd.loop_step = 1'b1;
                    state_next    = S_LOOP_RD;
                end
            end
            S_E_LO:
            begin
                cmd.e_lo   = 1'b1;
                state_next = S_E_HI;
            end
            S_E_HI:
            begin
                cmd.e_hi   = 1'b1;
                state_next = S_E_SUM;
            end
            S_E_SUM:
            begin
                cmd.e_sum  = 1'b1;
                state_next = S_E_ST;
            end
            S_E_ST:
            begin
                cmd.e_store = 1'b1;
                if (axis_reg == AXIS_Z)
                begin
                    axis_next  = AXIS_X;
                    state_next = S_FINISH;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_E_LO;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/voxel_grid_store_ray_caster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_grid_store_ray_caster
// Chunked voxel id store with voxel write, voxel read and grid ray cast.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to zero, one entry per cycle
// (MAX_CHUNKS_PER_AXIS^3 * CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_LENGTH entries,
// 262144 at the defaults); configuration writes are taken during the sweep
// but no item is. One item is worked at a time. A read or write passes
// through dispatch and a store check before the output transfer. A ray cast
// runs the restoring divider (start, 33 quotient bits, done) for each nonzero
// direction component and skips it for a zero one, then a setup multiply per
// axis, then a store read and a step per visited cell, then end point math on
// the shared multiplier. The output register lets a finished result wait
// while the next item is taken.
// ----------------------------------------------------------------------------
module voxel_grid_store_ray_caster #(
    parameter int CHUNK_WIDTH         = vgrc_pkg::DEF_CHUNK_WIDTH,
    parameter int CHUNK_HEIGHT        = vgrc_pkg::DEF_CHUNK_HEIGHT,
    parameter int CHUNK_LENGTH        = vgrc_pkg::DEF_CHUNK_LENGTH,
    parameter int MAX_CHUNKS_PER_AXIS = vgrc_pkg::DEF_MAX_CHUNKS_PER_AXIS,
    parameter int VOXEL_ID_BITS       = vgrc_pkg::DEF_VOXEL_ID_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  vgrc_pkg::vgrc_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output vgrc_pkg::vgrc_out_t            out_data,
    input  logic                           cfg_we,
    input  logic [vgrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vgrc_pkg::CFG_W-1:0]     cfg_data
);

    import vgrc_pkg::*;

    vgrc_cmd_t  cmd;
    vgrc_stat_t stat;

    vgrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    vgrc_datapath #(
        .CHUNK_WIDTH        (CHUNK_WIDTH),
        .CHUNK_HEIGHT       (CHUNK_HEIGHT),
        .CHUNK_LENGTH       (CHUNK_LENGTH),
        .MAX_CHUNKS_PER_AXIS(MAX_CHUNKS_PER_AXIS),
        .VOXEL_ID_BITS      (VOXEL_ID_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .out_data (out_data),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: verif/voxel_grid_store_ray_caster_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_grid_store_ray_caster_tb
// Drives voxel writes, reads, ray casts and unused actions through several world extents,
// predicts every result with a cycle-free model of the chunked store and the
// grid walk, and compares each output transfer field by field in order.
// ----------------------------------------------------------------------------
module voxel_grid_store_ray_caster_tb;

    import vgrc_pkg::*;

    class voxel_scoreboard;
        byte unsigned     cells[int];
        int unsigned      ext[3];
        vgrc_out_t        expected_q[$];
        int               errors;

        function new();
            ext = '{4, 4, 4};
            errors = 0;
        endfunction

        function void set_extent(int axis_i, int unsigned v);
            ext[axis_i] = (v > 4) ? 4 : v;
        endfunction

        function bit chunk_in(longint cx, longint cy, longint cz);
            return cx >= 0 && cx < ext[0] && cy >= 0 && cy < ext[1] && cz >= 0 && cz < ext[2];
        endfunction

        // floor split into chunk and local offset, 16 voxels per chunk axis
        function bit locate(longint x, longint y, longint z, output int idx,
                            output longint cx, cy, cz, lx, ly, lz);
            cx = x >>> 4; cy = y >>> 4; cz = z >>> 4;
            lx = x & 15;  ly = y & 15;  lz = z & 15;
            idx = int'((((cy * 4 + cz) * 4 + cx) * 4096) + (ly * 16 + lz) * 16 + lx);
            return chunk_in(cx, cy, cz);
        endfunction

        function byte unsigned peek(int idx);
            return cells.exists(idx) ? cells[idx] : 8'd0;
        endfunction

        function logic [15:0] sat16(longint v);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function logic [31:0] end_point(longint o, longint unsigned t, longint d);
            longint unsigned ad;
            longint unsigned mag;
            longint q;
            longint s;
            ad = (d < 0) ? -d : d;
            mag = t * ad;
            q = longint'(mag >> 16);
            s = o + ((d < 0) ? -q : q);
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            return s[31:0];
        endfunction

        function vgrc_out_t cast_ray(vgrc_in_t it);
            vgrc_out_t r;
            longint o[3], d[3], cpos[3], stp[3];
            longint unsigned delta[3], tm[3], t, frac, dist_v, ad;
            bit act[3], t_inf, lxy, lxz, lyz;
            longint maxd, cx, cy, cz, lx, ly, lz;
            int axis, k, steps, idx;
            r = '0;
            o = '{it.origin_x, it.origin_y, it.origin_z};
            d = '{it.direction_x, it.direction_y, it.direction_z};
            maxd = it.max_distance;
            t = 0;
            t_inf = 0;
            axis = -1;
            steps = 0;
            for (k = 0; k < 3; k++)
            begin
                cpos[k] = o[k] >>> 16;
                stp[k] = (d[k] > 0) ? 1 : -1;
                act[k] = d[k] != 0;
                ad = (d[k] < 0) ? -d[k] : d[k];
                delta[k] = act[k] ? (64'h1_0000_0000 / ad) : 0;
                frac = o[k] & 64'hFFFF;
                dist_v = (stp[k] > 0) ? 65536 - frac : frac;
                tm[k] = (delta[k] * dist_v) >> 16;
            end
            while (!t_inf && longint'(t) <= maxd)
            begin
                if (locate(cpos[0], cpos[1], cpos[2], idx, cx, cy, cz, lx, ly, lz)
                    && peek(idx) != 0)
                begin
                    r.found = 1'b1;
                    r.value_out = peek(idx);
                    r.cell_x = sat16(cpos[0]);
                    r.cell_y = sat16(cpos[1]);
                    r.cell_z = sat16(cpos[2]);
                    r.end_x = end_point(o[0], t, d[0]);
                    r.end_y = end_point(o[1], t, d[1]);
                    r.end_z = end_point(o[2], t, d[2]);
                    r.normal_code = (axis < 0) ? NORMAL_NONE
                                  : 3'(2 * axis + ((stp[axis] > 0) ? 1 : 2));
                    return r;
                end
                if (steps >= RAY_MAX_STEPS)
                    break;
                steps++;
                lxy = act[0] && (!act[1] || tm[0] < tm[1]);
                lxz = act[0] && (!act[2] || tm[0] < tm[2]);
                lyz = act[1] && (!act[2] || tm[1] < tm[2]);
                k = lxy ? (lxz ? 0 : 2) : (lyz ? 1 : 2);
                cpos[k] += stp[k];
                axis = k;
                if (!act[k])
                    t_inf = 1;
                else
                begin
                    t = tm[k];
                    tm[k] += delta[k];
                end
            end
            r.cell_x = sat16(cpos[0]);
            r.cell_y = sat16(cpos[1]);
            r.cell_z = sat16(cpos[2]);
            r.end_x = t_inf ? o[0][31:0] : end_point(o[0], t, d[0]);
            r.end_y = t_inf ? o[1][31:0] : end_point(o[1], t, d[1]);
            r.end_z = t_inf ? o[2][31:0] : end_point(o[2], t, d[2]);
            return r;
        endfunction

        function void note_input(vgrc_in_t it);
            vgrc_out_t r;
            longint cx, cy, cz, lx, ly, lz;
            int idx;
            bit in_world;
            r = '0;
            in_world = locate(it.voxel_x, it.voxel_y, it.voxel_z, idx, cx, cy, cz,
                              lx, ly, lz);
            case (it.action)
                ACT_WRITE:
                begin
                    if (in_world)
                    begin
                        r.found = 1'b1;
                        if (peek(idx) != it.voxel_value)
                        begin
                            cells[idx] = it.voxel_value;
                            r.marked_mask[0] = 1'b1;
                            r.marked_mask[1] = lx == 0  && chunk_in(cx - 1, cy, cz);
                            r.marked_mask[2] = lx == 15 && chunk_in(cx + 1, cy, cz);
                            r.marked_mask[3] = ly == 0  && chunk_in(cx, cy - 1, cz);
                            r.marked_mask[4] = ly == 15 && chunk_in(cx, cy + 1, cz);
                            r.marked_mask[5] = lz == 0  && chunk_in(cx, cy, cz - 1);
                            r.marked_mask[6] = lz == 15 && chunk_in(cx, cy, cz + 1);
                        end
                    end
                end
                ACT_READ:
                begin
                    if (in_world)
                    begin
                        r.found = 1'b1;
                        r.value_out = peek(idx);
                    end
                end
                ACT_CAST: r = cast_ray(it);
                default: r = '0;
            endcase
            expected_q.push_back(r);
        endfunction

        function void compare(string name, longint e, longint a);
            if (e != a)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(vgrc_out_t got);
            vgrc_out_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare("found", e.found, got.found);
            compare("value_out", e.value_out, got.value_out);
            compare("cell_x", e.cell_x, got.cell_x);
            compare("cell_y", e.cell_y, got.cell_y);
            compare("cell_z", e.cell_z, got.cell_z);
            compare("end_x", e.end_x, got.end_x);
            compare("end_y", e.end_y, got.end_y);
            compare("end_z", e.end_z, got.end_z);
            compare("normal_code", e.normal_code, got.normal_code);
            compare("marked_mask", e.marked_mask, got.marked_mask);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    vgrc_in_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    vgrc_out_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    voxel_scoreboard sb;
    bit              no_idle;
    logic [15:0]     last_x, last_y, last_z;

    voxel_grid_store_ray_caster dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 24);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    task automatic send(vgrc_in_t it);
        if (!no_idle && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(it);
    endtask

    task automatic drain();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_world(int unsigned ex, int unsigned ey, int unsigned ez);
        logic [CFG_IDX_W-1:0] idx_l[3];
        int unsigned          val_l[3];
        idx_l = '{CFG_CHUNKS_X, CFG_CHUNKS_Y, CFG_CHUNKS_Z};
        val_l = '{ex, ey, ez};
        drain();
        for (int i = 0; i < 3; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx_l[i];
            cfg_data <= val_l[i][CFG_W-1:0];
            @(posedge clk);
            sb.set_extent(i, val_l[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic vgrc_in_t voxel_op(logic [1:0] act, int x, int y, int z, int v);
        vgrc_in_t it;
        it = '0;
        it.action = act;
        it.voxel_x = x[15:0];
        it.voxel_y = y[15:0];
        it.voxel_z = z[15:0];
        it.voxel_value = v[7:0];
        return it;
    endfunction

    function automatic vgrc_in_t ray(int ox, int oy, int oz, int dx, int dy, int dz, int md);
        vgrc_in_t it;
        it = '0;
        it.action = ACT_CAST;
        it.origin_x = ox;
        it.origin_y = oy;
        it.origin_z = oz;
        it.direction_x = dx;
        it.direction_y = dy;
        it.direction_z = dz;
        it.max_distance = md;
        return it;
    endfunction

    function automatic int near_coord();
        return $urandom_range(99) < 10 ? int'($urandom_range(65535)) - 32768
                                        : int'($urandom_range(40)) - 4;
    endfunction

    function automatic int rand_dir();
        int v;
        if ($urandom_range(99) < 15)
            return 0;
        v = $urandom;
        return v >>> $urandom_range(20, 0);
    endfunction

    task automatic random_items(int count);
        vgrc_in_t it;
        int       sel, x, y, z;
        int       ox, oy, oz;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            it = '0;
            it.max_distance = $urandom;
            if (sel < 30)
            begin
                x = near_coord();
                y = near_coord();
                z = near_coord();
                it = voxel_op(ACT_WRITE, x, y, z,
                              $urandom_range(99) < 15 ? 0 : $urandom_range(255));
                last_x = x[15:0];
                last_y = y[15:0];
                last_z = z[15:0];
            end
            else if (sel < 55)
                it = voxel_op(ACT_READ, near_coord(), near_coord(), near_coord(), $urandom);
            else if (sel < 75)
            begin
                // aim at the most recently written voxel from a few cells away
                ox = (int'($signed(last_x)) + int'($urandom_range(8)) - 4) * 65536
                     + int'($urandom_range(65535));
                oy = (int'($signed(last_y)) + int'($urandom_range(8)) - 4) * 65536
                     + int'($urandom_range(65535));
                oz = (int'($signed(last_z)) + int'($urandom_range(8)) - 4) * 65536
                     + int'($urandom_range(65535));
                it = ray(ox, oy, oz,
                         int'($signed(last_x)) * 65536 + 32768 - ox,
                         int'($signed(last_y)) * 65536 + 32768 - oy,
                         int'($signed(last_z)) * 65536 + 32768 - oz,
                         $urandom_range(20 * 65536));
            end
            else if (sel < 95)
            begin
                it = ray(near_coord() * 65536 + int'($urandom_range(65535)),
                         near_coord() * 65536 + int'($urandom_range(65535)),
                         near_coord() * 65536 + int'($urandom_range(65535)),
                         rand_dir(), rand_dir(), rand_dir(),
                         $urandom_range(99) < 10 ? int'($urandom)
                                                 : int'($urandom_range(48 * 65536)));
                if ($urandom_range(99) < 10)
                    it.origin_x = $urandom;
            end
            else if (sel < 98)
                it.action = ACT_NONE;
            send(it);
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        sb = new();
        no_idle = 1'b0;
        last_x = '0;
        last_y = '0;
        last_z = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CHUNKS_X;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_world(4, 4, 4);
        // directed: edges of the world, id changes, unused action, ray corner cases
        send(voxel_op(ACT_WRITE, 0, 0, 0, 5));
        send(voxel_op(ACT_WRITE, 15, 15, 15, 9));
        send(voxel_op(ACT_WRITE, 16, 16, 16, 255));
        send(voxel_op(ACT_WRITE, 16, 16, 16, 255));
        send(voxel_op(ACT_WRITE, 63, 63, 63, 1));
        send(voxel_op(ACT_WRITE, -1, 0, 0, 7));
        send(voxel_op(ACT_WRITE, 32767, -32768, 64, 7));
        send(voxel_op(ACT_WRITE, 63, 63, 63, 0));
        send(voxel_op(ACT_READ, 0, 0, 0, 0));
        send(voxel_op(ACT_READ, 16, 16, 16, 0));
        send(voxel_op(ACT_READ, -32768, 32767, -1, 0));
        begin
            vgrc_in_t junk;
            junk = '1;
            junk.action = ACT_NONE;
            send(junk);
        end
        send(ray(32768, 32768, 32768, 0, 0, 0, 65536));
        send(ray(-3 * 65536 - 32768, 32768, 32768, 65536, 0, 0, 10 * 65536));
        send(ray(20 * 65536 + 32768, 15 * 65536 + 32768, 15 * 65536 + 32768,
                 -65536, 0, 0, 10 * 65536));
        send(ray(2 * 65536 + 32768, 2 * 65536, 2 * 65536, 0, 0, 0, 65536));
        send(ray(32768, 32768, 32768, 65536, 65536, 65536, -1));
        send(ray(-20000 * 65536, 5 * 65536, 5 * 65536, 65536, 0, 0, 32'h7FFF_FFFF));
        send(ray(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                 32'h7FFF_FFFF));
        send(ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, -1,
                 32'h8000_0000));
        send(ray(5 * 65536, 5 * 65536, 5 * 65536, -65536, -65536, -65536, 32 * 65536));
        random_items(180);

        set_world(1, 2, 3);
        random_items(150);

        set_world(0, 4, 7);
        random_items(50);

        set_world(4, 4, 4);
        no_idle = 1'b1;
        random_items(100);
        no_idle = 1'b0;
        random_items(120);

        drain();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
